// ===== hw/rtl/tts_pkg.sv =====
`default_nettype none
package tts_pkg;

   localparam int MAX_POPULATION = 256;
   localparam int POP_BITS       = $clog2(MAX_POPULATION);
   localparam int WORD_BITS      = 32;
   localparam int MAX_WORDS      = 8;
   localparam int WSEL_BITS      = $clog2(MAX_WORDS);
   localparam int GENE_ADDR_BITS = POP_BITS + WSEL_BITS;
   localparam int FITNESS_BITS   = 32;
   localparam int LEN_BITS       = 12;
   localparam int GCOUNT_BITS    = 9;
   localparam int CNT_BITS       = 9;
   localparam int PCNT_BITS      = $clog2(WORD_BITS + 1);

   // commands
   localparam logic [1:0] CMD_HEADER = 2'd0;
   localparam logic [1:0] CMD_GENE   = 2'd1;
   localparam logic [1:0] CMD_ORDER  = 2'd2;
   localparam logic [1:0] CMD_SELECT = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_WRITE_DONE = 2'd0;
   localparam logic [1:0] STATUS_WINNER     = 2'd1;
   localparam logic [1:0] STATUS_RESHUFFLE  = 2'd2;

   // select modes
   localparam logic [1:0] MODE_SEQUENTIAL = 2'd0;
   localparam logic [1:0] MODE_SHUFFLED   = 2'd1;

   // register indexes
   localparam logic [2:0] REG_POPULATION_SIZE = 3'd0;
   localparam logic [2:0] REG_PROBLEM_LENGTH  = 3'd1;
   localparam logic [2:0] REG_CANDIDATE_LIMIT = 3'd2;
   localparam logic [2:0] REG_SELECT_MODE     = 3'd3;
   localparam logic [2:0] REG_MAXIMIZE        = 3'd4;
   localparam logic [2:0] REG_TIE_BY_LENGTH   = 3'd5;

   typedef struct packed {
      logic [1:0]                     cmd;
      logic [7:0]                     index;
      logic [2:0]                     word_index;
      logic signed [FITNESS_BITS-1:0] fitness_value;
      logic [LEN_BITS-1:0]            chrom_len;
      logic [GCOUNT_BITS-1:0]         gene_count;
      logic [WORD_BITS-1:0]           gene_word;
      logic [7:0]                     order_value;
      logic                           tie_coin;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [7:0]          winner;
      logic                match_found;
      logic [CNT_BITS-1:0] shared_genes;
   } rsp_type;

   typedef struct packed {
      logic [POP_BITS-1:0]       ind_addr;
      logic                      ind_we;
      logic [FITNESS_BITS-1:0]   fit_wd;
      logic [LEN_BITS-1:0]       len_wd;
      logic [GCOUNT_BITS-1:0]    gc_wd;
      logic [GENE_ADDR_BITS-1:0] gene_addr;
      logic                      gene_we;
      logic [WORD_BITS-1:0]      gene_wd;
      logic [POP_BITS-1:0]       ord_addr;
      logic                      ord_we;
      logic [7:0]                ord_wd;
   } mem_req_type;

   typedef struct packed {
      logic [FITNESS_BITS-1:0] fit_q;
      logic [LEN_BITS-1:0]     len_q;
      logic [GCOUNT_BITS-1:0]  gc_q;
      logic [WORD_BITS-1:0]    gene_q;
      logic [7:0]              ord_q;
   } mem_rsp_type;

   function automatic logic [PCNT_BITS-1:0] popcount(input logic [WORD_BITS-1:0] v);
      logic [PCNT_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         n = n + PCNT_BITS'(v[i]);
      end
      return n;
   endfunction

   // ones below the remaining gene position count
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [8:0] left);
      logic [WORD_BITS-1:0] m;
      if (left >= 9'(WORD_BITS)) begin
         m = '1;
      end else begin
         m = (WORD_BITS'(1) << left[PCNT_BITS-2:0]) - WORD_BITS'(1);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/threshold_tournament_selector.sv =====
`default_nettype none
// channel   ports                         direction  accepted when
// request   req_valid req_stall req_data  in         req_valid && !req_stall
// response  rsp_valid rsp_stall rsp_data  out        rsp_valid && !rsp_stall
// config    csr_write_en csr_index csr_wdata  in     csr_write_en
//
// one word at a time: the sequencer owns a single set of table ports and one
// popcount/compare path, so it takes no new request word until the result of
// the last one has gone into the response register
// sync reset clears control state and loads the config defaults; tables stay
// unknown; a stalled response holds and the next result waits for it
module threshold_tournament_selector (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output tts_pkg::rsp_type rsp_data,
   input  wire              csr_write_en,
   input  wire [2:0]        csr_index,
   input  wire [8:0]        csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_FIRST, S_GOT_FIRST, S_SECOND, S_GOT_SECOND,
      S_CAND, S_CORD, S_CGC1, S_CGC2, S_GW_A, S_GW_B, S_GW_C,
      S_THR, S_THR2, S_SWAP_RD, S_SWAP_W1, S_SWAP_W2,
      S_FIT_A, S_FIT_B, S_FIT_C, S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [8:0] pop_size_ff, plen_cfg_ff;
   logic [7:0] limit_ff;
   logic [1:0] mode_ff;
   logic       maximize_ff, tie_len_ff;

   logic [8:0]  pp_ff;
   logic [7:0]  first_ff, second_ff, slot_ff, k_ff;
   logic [8:0]  g1_ff;
   logic [17:0] prod_ff, thr_ff;
   logic [2:0]  w_ff;
   logic [8:0]  left_ff, cnt_ff;
   logic [31:0] gword_ff;
   logic [31:0] fa_ff;
   logic [11:0] la_ff;
   logic        match_ff, coin_ff;
   tts_pkg::rsp_type res_ff;
   logic             rsp_valid_ff;
   tts_pkg::rsp_type rsp_data_ff;

   tts_pkg::mem_req_type mem_req;
   tts_pkg::mem_rsp_type mem_rsp;

   logic [8:0] pop, plen, pop_m1, base0, left_nx, cnt_nx;
   logic [8:0] slot_inc;
   logic [7:0] slot_nx, win;
   logic       wrap, req_take, out_free, fit_eq, fit_gt;

   tts_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   // saturated population and problem length
   always_comb begin
      pop = pop_size_ff;
      if (pop < 9'd2) pop = 9'd2;
      if (pop > 9'(tts_pkg::MAX_POPULATION)) pop = 9'(tts_pkg::MAX_POPULATION);
      plen = plen_cfg_ff;
      if (plen < 9'd1) plen = 9'd1;
      if (plen > 9'(tts_pkg::MAX_WORDS * tts_pkg::WORD_BITS)) begin
         plen = 9'(tts_pkg::MAX_WORDS * tts_pkg::WORD_BITS);
      end
   end

   assign pop_m1   = pop - 9'd1;
   assign wrap     = (pp_ff >= pop_m1);
   assign base0    = wrap ? 9'd0 : pp_ff;
   assign slot_inc = {1'b0, slot_ff} + 9'd1;
   assign slot_nx  = (slot_inc == pop) ? 8'd0 : slot_inc[7:0];
   assign left_nx  = (left_ff > 9'(tts_pkg::WORD_BITS)) ?
                     left_ff - 9'(tts_pkg::WORD_BITS) : 9'd0;
   assign cnt_nx   = cnt_ff + 9'(tts_pkg::popcount(gword_ff & mem_rsp.gene_q &
                                                   tts_pkg::low_mask(left_ff)));
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // winner of the pair held in first/second
   assign fit_eq = (fa_ff == mem_rsp.fit_q);
   assign fit_gt = ($signed(fa_ff) > $signed(mem_rsp.fit_q));
   always_comb begin
      if (fit_eq) begin
         if (tie_len_ff) begin
            win = (la_ff < mem_rsp.len_q) ? first_ff : second_ff;
         end else begin
            win = coin_ff ? first_ff : second_ff;
         end
      end else begin
         win = (fit_gt == maximize_ff) ? first_ff : second_ff;
      end
   end

   // table port control
   always_comb begin
      mem_req           = '0;
      mem_req.fit_wd    = req_data.fitness_value;
      mem_req.len_wd    = req_data.chrom_len;
      mem_req.gc_wd     = req_data.gene_count;
      mem_req.gene_wd   = req_data.gene_word;
      mem_req.ord_wd    = req_data.order_value;
      mem_req.ind_addr  = first_ff;
      mem_req.gene_addr = {first_ff, w_ff};
      mem_req.ord_addr  = pp_ff[7:0];
      case (state_ff)
         S_IDLE: begin
            mem_req.ind_addr  = req_data.index;
            mem_req.gene_addr = {req_data.index, req_data.word_index};
            mem_req.ord_addr  = req_data.index;
            mem_req.ind_we    = req_take && (req_data.cmd == tts_pkg::CMD_HEADER);
            mem_req.gene_we   = req_take && (req_data.cmd == tts_pkg::CMD_GENE);
            mem_req.ord_we    = req_take && (req_data.cmd == tts_pkg::CMD_ORDER);
         end
         S_SECOND, S_SWAP_RD: begin
            mem_req.ord_addr = pp_ff[7:0] + 8'd1;
         end
         S_CORD: begin
            mem_req.ord_addr = slot_ff;
         end
         S_CGC1: begin
            mem_req.ind_addr = mem_rsp.ord_q;
         end
         S_GW_B: begin
            mem_req.gene_addr = {second_ff, w_ff};
         end
         S_SWAP_W1: begin
            mem_req.ord_addr = slot_ff;
            mem_req.ord_wd   = mem_rsp.ord_q;
            mem_req.ord_we   = 1'b1;
         end
         S_SWAP_W2: begin
            mem_req.ord_addr = pp_ff[7:0] + 8'd1;
            mem_req.ord_wd   = second_ff;
            mem_req.ord_we   = 1'b1;
         end
         S_FIT_B: begin
            mem_req.ind_addr = second_ff;
         end
         default: begin
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pop_size_ff  <= 9'd256;
         plen_cfg_ff  <= 9'd256;
         limit_ff     <= 8'd16;
         mode_ff      <= tts_pkg::MODE_SEQUENTIAL;
         maximize_ff  <= 1'b1;
         tie_len_ff   <= 1'b1;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               tts_pkg::REG_POPULATION_SIZE: pop_size_ff <= csr_wdata;
               tts_pkg::REG_PROBLEM_LENGTH:  plen_cfg_ff <= csr_wdata;
               tts_pkg::REG_CANDIDATE_LIMIT: limit_ff    <= csr_wdata[7:0];
               tts_pkg::REG_SELECT_MODE:     mode_ff     <= csr_wdata[1:0];
               tts_pkg::REG_MAXIMIZE:        maximize_ff <= csr_wdata[0];
               tts_pkg::REG_TIE_BY_LENGTH:   tie_len_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         // S_OUT handles the response register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  coin_ff  <= req_data.tie_coin;
                  match_ff <= 1'b0;
                  cnt_ff   <= '0;
                  if (req_data.cmd != tts_pkg::CMD_SELECT) begin
                     // table write goes to the store on this edge
                     res_ff   <= '0;
                     state_ff <= S_OUT;
                  end else if (mode_ff == tts_pkg::MODE_SEQUENTIAL) begin
                     res_ff    <= '0;
                     first_ff  <= base0[7:0];
                     second_ff <= base0[7:0] + 8'd1;
                     pp_ff     <= base0 + 9'd2;
                     state_ff  <= S_FIT_A;
                  end else if (wrap) begin
                     pp_ff               <= '0;
                     res_ff.status       <= tts_pkg::STATUS_RESHUFFLE;
                     res_ff.winner       <= '0;
                     res_ff.match_found  <= 1'b0;
                     res_ff.shared_genes <= '0;
                     state_ff            <= S_OUT;
                  end else begin
                     res_ff   <= '0;
                     state_ff <= S_FIRST;
                  end
               end
            end
            S_FIRST: begin
               state_ff <= S_GOT_FIRST;
            end
            S_GOT_FIRST: begin
               first_ff <= mem_rsp.ord_q;
               k_ff     <= '0;
               slot_ff  <= pp_ff[7:0];
               state_ff <= (mode_ff == tts_pkg::MODE_SHUFFLED) ? S_SECOND : S_CAND;
            end
            S_SECOND: begin
               state_ff <= S_GOT_SECOND;
            end
            S_GOT_SECOND: begin
               second_ff <= mem_rsp.ord_q;
               state_ff  <= S_FIT_A;
            end
            S_CAND: begin
               if (k_ff == limit_ff) begin
                  // nothing above threshold: the first individual wins
                  res_ff.status <= tts_pkg::STATUS_WINNER;
                  res_ff.winner <= first_ff;
                  pp_ff         <= pp_ff + 9'd1;
                  state_ff      <= S_OUT;
               end else begin
                  k_ff     <= k_ff + 8'd1;
                  slot_ff  <= slot_nx;
                  state_ff <= S_CORD;
               end
            end
            S_CORD: begin
               state_ff <= S_CGC1;
            end
            S_CGC1: begin
               second_ff <= mem_rsp.ord_q;
               g1_ff     <= mem_rsp.gc_q;
               state_ff  <= S_CGC2;
            end
            S_CGC2: begin
               prod_ff  <= 18'(g1_ff) * 18'(mem_rsp.gc_q);
               w_ff     <= '0;
               left_ff  <= plen;
               cnt_ff   <= '0;
               state_ff <= S_GW_A;
            end
            S_GW_A: begin
               state_ff <= S_GW_B;
            end
            S_GW_B: begin
               gword_ff <= mem_rsp.gene_q;
               state_ff <= S_GW_C;
            end
            S_GW_C: begin
               cnt_ff  <= cnt_nx;
               left_ff <= left_nx;
               w_ff    <= w_ff + 3'd1;
               if (left_nx == 9'd0 || w_ff == 3'(tts_pkg::MAX_WORDS - 1)) begin
                  state_ff <= S_THR;
               end else begin
                  state_ff <= S_GW_A;
               end
            end
            S_THR: begin
               thr_ff   <= 18'(cnt_ff) * 18'(plen);
               state_ff <= S_THR2;
            end
            S_THR2: begin
               // count > g1*g2/plen  <=>  g1*g2 < count*plen
               state_ff <= (prod_ff < thr_ff) ? S_SWAP_RD : S_CAND;
            end
            S_SWAP_RD: begin
               state_ff <= S_SWAP_W1;
            end
            S_SWAP_W1: begin
               state_ff <= S_SWAP_W2;
            end
            S_SWAP_W2: begin
               match_ff <= 1'b1;
               state_ff <= S_FIT_A;
            end
            S_FIT_A: begin
               state_ff <= S_FIT_B;
            end
            S_FIT_B: begin
               fa_ff    <= mem_rsp.fit_q;
               la_ff    <= mem_rsp.len_q;
               state_ff <= S_FIT_C;
            end
            S_FIT_C: begin
               res_ff.status       <= tts_pkg::STATUS_WINNER;
               res_ff.winner       <= win;
               res_ff.match_found  <= match_ff;
               res_ff.shared_genes <= match_ff ? cnt_ff : 9'd0;
               if (mode_ff != tts_pkg::MODE_SEQUENTIAL) begin
                  pp_ff <= pp_ff + 9'd2;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tts_store.sv =====
`default_nettype none
module tts_store (
   input  wire                  clock,
   input  tts_pkg::mem_req_type mem_req,
   output tts_pkg::mem_rsp_type mem_rsp
);

   logic [tts_pkg::FITNESS_BITS-1:0] fit_mem  [tts_pkg::MAX_POPULATION];
   logic [tts_pkg::LEN_BITS-1:0]     len_mem  [tts_pkg::MAX_POPULATION];
   logic [tts_pkg::GCOUNT_BITS-1:0]  gc_mem   [tts_pkg::MAX_POPULATION];
   logic [tts_pkg::WORD_BITS-1:0]    gene_mem [tts_pkg::MAX_POPULATION * tts_pkg::MAX_WORDS];
   logic [7:0]                       ord_mem  [tts_pkg::MAX_POPULATION];

   always_ff @(posedge clock) begin
      if (mem_req.ind_we) begin
         fit_mem[mem_req.ind_addr] <= mem_req.fit_wd;
         len_mem[mem_req.ind_addr] <= mem_req.len_wd;
         gc_mem[mem_req.ind_addr]  <= mem_req.gc_wd;
      end
      if (mem_req.gene_we) begin
         gene_mem[mem_req.gene_addr] <= mem_req.gene_wd;
      end
      if (mem_req.ord_we) begin
         ord_mem[mem_req.ord_addr] <= mem_req.ord_wd;
      end
      mem_rsp.fit_q  <= fit_mem[mem_req.ind_addr];
      mem_rsp.len_q  <= len_mem[mem_req.ind_addr];
      mem_rsp.gc_q   <= gc_mem[mem_req.ind_addr];
      mem_rsp.gene_q <= gene_mem[mem_req.gene_addr];
      mem_rsp.ord_q  <= ord_mem[mem_req.ord_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tts_checker.sv =====
`default_nettype none
module tts_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input tts_pkg::rsp_type rsp_data
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_no_winner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != tts_pkg::STATUS_WINNER |->
         rsp_data.winner == 8'd0 && !rsp_data.match_found &&
         rsp_data.shared_genes == 9'd0)
      else $error("non-select response carries tournament data");

   a_shared_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.match_found |-> rsp_data.shared_genes == 9'd0)
      else $error("shared count without a match");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("took a second word without finishing the first");

endmodule

bind threshold_tournament_selector tts_checker u_tts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// ===== verif/threshold_tournament_selector_tb.sv =====
module threshold_tournament_selector_tb;

   timeunit 1ns;
   timeprecision 1ps;

   // the package names modes 0 and 1 only; 2 is the thresholding scan
   localparam logic [1:0] MODE_THRESHOLD = 2'd2;
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   // individuals and order slots that are loaded and ever addressed
   localparam int NUM_IND = 16;

   // tournament predictor: private copy of the tables, pair pointer and registers
   class tournament_scoreboard;
      logic signed [tts_pkg::FITNESS_BITS-1:0] fit_tab [tts_pkg::MAX_POPULATION];
      logic [tts_pkg::LEN_BITS-1:0]    len_tab [tts_pkg::MAX_POPULATION];
      logic [tts_pkg::GCOUNT_BITS-1:0] gcount_tab [tts_pkg::MAX_POPULATION];
      logic [tts_pkg::WORD_BITS-1:0]   gene_tab [tts_pkg::MAX_POPULATION*tts_pkg::MAX_WORDS];
      logic [7:0]                      order_tab [tts_pkg::MAX_POPULATION];
      int unsigned pair_ptr;
      int unsigned pop_reg, plen_reg, limit_reg;
      logic [1:0]  mode_reg;
      bit          maximize_reg, tie_len_reg;
      tts_pkg::rsp_type pending_rsp [$];
      int          mismatches;
      int          selects, match_count, reshuffles;

      function new();
         pair_ptr = 0;
         pop_reg = 256; plen_reg = 256; limit_reg = 16;
         mode_reg = tts_pkg::MODE_SEQUENTIAL; maximize_reg = 1; tie_len_reg = 1;
         mismatches = 0; selects = 0; match_count = 0; reshuffles = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [8:0] val);
         case (idx)
            tts_pkg::REG_POPULATION_SIZE: pop_reg = 32'(val);
            tts_pkg::REG_PROBLEM_LENGTH:  plen_reg = 32'(val);
            tts_pkg::REG_CANDIDATE_LIMIT: limit_reg = 32'(val[7:0]);
            tts_pkg::REG_SELECT_MODE:     mode_reg = val[1:0];
            tts_pkg::REG_MAXIMIZE:        maximize_reg = val[0];
            tts_pkg::REG_TIE_BY_LENGTH:   tie_len_reg = val[0];
            default: ;
         endcase
      endfunction

      function int unsigned live_pop();
         if (pop_reg < 2) return 2;
         if (pop_reg > tts_pkg::MAX_POPULATION) return tts_pkg::MAX_POPULATION;
         return pop_reg;
      endfunction

      function int unsigned live_plen();
         if (plen_reg < 1) return 1;
         if (plen_reg > tts_pkg::MAX_WORDS*tts_pkg::WORD_BITS) begin
            return tts_pkg::MAX_WORDS*tts_pkg::WORD_BITS;
         end
         return plen_reg;
      endfunction

      // popcount of the AND over the counted gene positions
      function int unsigned common_genes(int unsigned a, int unsigned b);
         int unsigned left, n;
         logic [tts_pkg::WORD_BITS-1:0] x;
         left = live_plen();
         n = 0;
         for (int w = 0; w < tts_pkg::MAX_WORDS && left > 0; w++) begin
            x = gene_tab[a*tts_pkg::MAX_WORDS+w] & gene_tab[b*tts_pkg::MAX_WORDS+w];
            if (left < tts_pkg::WORD_BITS) begin
               x = x & ((32'd1 << left) - 32'd1);
               left = 0;
            end else begin
               left = left - tts_pkg::WORD_BITS;
            end
            n = n + $countones(x);
         end
         return n;
      endfunction

      function logic [7:0] fitter(int unsigned a, int unsigned b, bit coin);
         if (fit_tab[a] == fit_tab[b]) begin
            if (tie_len_reg) return (len_tab[a] < len_tab[b]) ? a[7:0] : b[7:0];
            return coin ? a[7:0] : b[7:0];
         end
         if (fit_tab[a] > fit_tab[b]) return maximize_reg ? a[7:0] : b[7:0];
         return maximize_reg ? b[7:0] : a[7:0];
      endfunction

      function void note_word(tts_pkg::req_type w);
         tts_pkg::rsp_type e;
         int unsigned pop, p, first, second, slot, cnt, thr;
         logic [7:0] t;
         e = '0;
         case (w.cmd)
            tts_pkg::CMD_HEADER: begin
               fit_tab[w.index] = w.fitness_value;
               len_tab[w.index] = w.chrom_len;
               gcount_tab[w.index] = w.gene_count;
            end
            tts_pkg::CMD_GENE:  gene_tab[{w.index, w.word_index}] = w.gene_word;
            tts_pkg::CMD_ORDER: order_tab[w.index] = w.order_value;
            default: begin
               selects++;
               pop = live_pop();
               if (mode_reg == tts_pkg::MODE_SEQUENTIAL) begin
                  if (pair_ptr >= pop - 1) pair_ptr = 0;
                  e.winner = fitter(pair_ptr % 256, (pair_ptr + 1) % 256, w.tie_coin);
                  pair_ptr += 2;
                  e.status = tts_pkg::STATUS_WINNER;
               end else if (pair_ptr >= pop - 1) begin
                  // shuffled modes hand the wrap back to the host
                  pair_ptr = 0;
                  e.status = tts_pkg::STATUS_RESHUFFLE;
                  reshuffles++;
               end else if (mode_reg == tts_pkg::MODE_SHUFFLED) begin
                  e.winner = fitter(32'(order_tab[pair_ptr]), 32'(order_tab[pair_ptr+1]),
                                    w.tie_coin);
                  pair_ptr += 2;
                  e.status = tts_pkg::STATUS_WINNER;
               end else begin
                  p = pair_ptr;
                  first = 32'(order_tab[p]);
                  e.winner = first[7:0];
                  for (int unsigned k = 1; k <= limit_reg; k++) begin
                     slot = (p + k) % pop;
                     second = 32'(order_tab[slot]);
                     cnt = common_genes(first, second);
                     thr = (32'(gcount_tab[first]) * 32'(gcount_tab[second])) / live_plen();
                     if (cnt > thr) begin
                        // partner moves into the slot after the first
                        t = order_tab[slot];
                        order_tab[slot] = order_tab[p+1];
                        order_tab[p+1] = t;
                        e.winner = fitter(first, second, w.tie_coin);
                        e.match_found = 1'b1;
                        e.shared_genes = cnt[8:0];
                        match_count++;
                        pair_ptr++;
                        break;
                     end
                  end
                  pair_ptr++;
                  e.status = tts_pkg::STATUS_WINNER;
               end
               pair_ptr &= 32'h1FF;
            end
         endcase
         pending_rsp.push_back(e);
      endfunction

      function void check_word(tts_pkg::rsp_type r);
         tts_pkg::rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing pending: %h", r);
            mismatches++;
            return;
         end
         e = pending_rsp.pop_front();
         if (r.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, r.status);
            mismatches++;
         end
         if (r.winner !== e.winner) begin
            $error("winner expected %0d actual %0d", e.winner, r.winner);
            mismatches++;
         end
         if (r.match_found !== e.match_found) begin
            $error("match_found expected %0d actual %0d", e.match_found, r.match_found);
            mismatches++;
         end
         if (r.shared_genes !== e.shared_genes) begin
            $error("shared_genes expected %0d actual %0d", e.shared_genes, r.shared_genes);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   tts_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   tts_pkg::rsp_type rsp_data;
   logic       csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;

   tournament_scoreboard sb = new();
   int send_idle_pct  = 0;  // chance of a gap before each request word
   int stall_pct      = 0;  // chance of stalling the response side each cycle
   int random_words   = 0;

   threshold_tournament_selector DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= (!reset && $urandom_range(0, 99) < stall_pct);
   end

   // response monitor, samples pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
   end

   // one request word; valid stays high across back-to-back words
   task automatic send_word(input tts_pkg::req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(w);
   endtask

   // drain everything, then write one register while the block is idle
   task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic configure(input logic [8:0] pop, input logic [8:0] plen,
                            input logic [7:0] lim, input logic [1:0] mode,
                            input bit maxi, input bit tie_len);
      write_reg(tts_pkg::REG_POPULATION_SIZE, pop);
      write_reg(tts_pkg::REG_PROBLEM_LENGTH, plen);
      write_reg(tts_pkg::REG_CANDIDATE_LIMIT, {1'b0, lim});
      write_reg(tts_pkg::REG_SELECT_MODE, {7'd0, mode});
      write_reg(tts_pkg::REG_MAXIMIZE, {8'd0, maxi});
      write_reg(tts_pkg::REG_TIE_BY_LENGTH, {8'd0, tie_len});
   endtask

   function automatic tts_pkg::req_type random_word(input logic [1:0] cmd);
      tts_pkg::req_type w;
      w = '0;
      w.cmd = cmd;
      w.index = 8'($urandom_range(0, NUM_IND - 1));
      w.word_index = 3'($urandom_range(0, 7));
      w.fitness_value = $urandom();
      // narrow fitness spread now and then so ties happen
      if ($urandom_range(0, 3) == 0) w.fitness_value = 32'($urandom_range(0, 3));
      w.chrom_len = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 2)) :
                                                  12'($urandom_range(0, 4095));
      // small gene counts keep the threshold reachable
      w.gene_count = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511)) :
                                                   9'($urandom_range(0, 40));
      w.gene_word = $urandom();
      if ($urandom_range(0, 3) == 0) w.gene_word = w.gene_word & $urandom();
      w.order_value = 8'($urandom_range(0, NUM_IND - 1));
      w.tie_coin = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // mixed phase: mostly selects, table rewrites sprinkled in
   task automatic run_words(input int n, input bit count_random);
      tts_pkg::req_type w;
      logic [1:0] c;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: c = tts_pkg::CMD_HEADER;
            1: c = tts_pkg::CMD_GENE;
            2: c = tts_pkg::CMD_ORDER;
            default: c = tts_pkg::CMD_SELECT;
         endcase
         w = random_word(c);
         if (count_random) begin
            random_words++;
            if (random_words < 107) begin
               send_idle_pct = 8;  stall_pct = 53;
            end else if (random_words < 214) begin
               send_idle_pct = 53; stall_pct = 8;
            end else begin
               send_idle_pct = 0;  stall_pct = 0;
            end
         end
         send_word(w);
      end
   endtask

   initial begin
      tts_pkg::req_type w;
      logic [8:0] pop, plen;
      logic [7:0] lim;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load every individual and order slot that a select can reach
      for (int i = 0; i < NUM_IND; i++) begin
         w = random_word(tts_pkg::CMD_HEADER);
         w.index = i[7:0];
         case (i)
            0: w.fitness_value = 32'sh8000_0000;  // most negative
            1: w.fitness_value = 32'sh7FFF_FFFF;  // most positive
            2, 3: begin w.fitness_value = 32'sd5; w.chrom_len = 12'd7; end
            4: begin w.fitness_value = 32'sd9; w.chrom_len = 12'd4095; end
            5: begin w.fitness_value = 32'sd9; w.chrom_len = 12'd0; end
            default: ;
         endcase
         send_word(w);
         for (int j = 0; j < tts_pkg::MAX_WORDS; j++) begin
            w = random_word(tts_pkg::CMD_GENE);
            w.index = i[7:0]; w.word_index = j[2:0];
            send_word(w);
         end
         w = random_word(tts_pkg::CMD_ORDER);
         w.index = i[7:0];
         send_word(w);
      end

      // directed: extremes, tie rules, every mode, out-of-range registers
      configure(9'd6, 9'd256, 8'd16, tts_pkg::MODE_SEQUENTIAL, 1'b1, 1'b1);
      for (int i = 0; i < 4; i++) begin
         w = random_word(tts_pkg::CMD_SELECT); w.tie_coin = i[0]; send_word(w);
      end
      configure(9'd6, 9'd256, 8'd16, tts_pkg::MODE_SEQUENTIAL, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) begin
         w = random_word(tts_pkg::CMD_SELECT); w.tie_coin = i[0]; send_word(w);
      end
      // pair wrap in sequential mode, then population saturated at the top
      configure(9'd2, 9'd256, 8'd16, tts_pkg::MODE_SEQUENTIAL, 1'b1, 1'b1);
      send_word(random_word(tts_pkg::CMD_SELECT));
      configure(9'd511, 9'd256, 8'd16, tts_pkg::MODE_SEQUENTIAL, 1'b1, 1'b1);
      for (int i = 0; i < 2; i++) send_word(random_word(tts_pkg::CMD_SELECT));
      // pair wrap in shuffled mode and saturated population
      configure(9'd0, 9'd0, 8'd0, tts_pkg::MODE_SHUFFLED, 1'b1, 1'b1);
      for (int i = 0; i < 3; i++) send_word(random_word(tts_pkg::CMD_SELECT));
      // limit zero, then mode three with oversized length and longest scan
      configure(9'd8, 9'd1, 8'd0, MODE_THRESHOLD, 1'b1, 1'b0);
      for (int i = 0; i < 3; i++) send_word(random_word(tts_pkg::CMD_SELECT));
      configure(9'(NUM_IND), 9'd511, 8'd255, MODE_SPARE, 1'b0, 1'b1);
      for (int i = 0; i < 4; i++) send_word(random_word(tts_pkg::CMD_SELECT));
      // scan wrapping past the end of a tiny population
      configure(9'd3, 9'd33, 8'd7, MODE_THRESHOLD, 1'b1, 1'b1);
      for (int i = 0; i < 4; i++) send_word(random_word(tts_pkg::CMD_SELECT));

      // random phases, each with its own register setting
      while (random_words < 320) begin
         pop  = 9'($urandom_range(0, NUM_IND));
         plen = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511)) :
                                              9'($urandom_range(1, 256));
         lim  = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 20));
         configure(pop, plen, lim, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         run_words($urandom_range(20, 60), 1'b1);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d selects, %0d threshold matches, %0d reshuffle returns",
               sb.selects, sb.match_count, sb.reshuffles);
      $display("over %0d random words plus table loading and directed register cases",
               random_words);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // run-away guard
   initial begin
      #200ms;
      $display("Mismatches found");
      $finish;
   end

endmodule
